@@ design/gtdf_pkg.sv @@
package gtdf_pkg;

  localparam int unsigned PIX_BITS   = 8;
  localparam int unsigned SUM_BITS   = 15;
  localparam int unsigned RECIP_BITS = 13;
  localparam int unsigned PROD_BITS  = SUM_BITS + RECIP_BITS;
  localparam int unsigned GRAY_SHIFT = 19;
  localparam int unsigned PCT_BITS   = 7;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 8;

  localparam logic [SUM_BITS-1:0]   W_RED      = 15'd30;
  localparam logic [SUM_BITS-1:0]   W_GREEN    = 15'd59;
  localparam logic [SUM_BITS-1:0]   W_BLUE     = 15'd11;
  localparam logic [RECIP_BITS-1:0] GRAY_RECIP = 13'd5243;
  localparam logic [PCT_BITS-1:0]   PCT_SCALE  = 7'd100;

  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DARK      = 2'd1;

  localparam logic [PIX_BITS-1:0] THRESHOLD_RST = 8'd127;
  localparam logic [PCT_BITS-1:0] DARK_RST      = 7'd50;

  typedef struct packed {
    logic [PIX_BITS-1:0] gray;
    logic                white;
    logic                last;
  } pix_t;

endpackage

@@ design/gtdf_queue.sv @@
module gtdf_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             valid_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign full_o     = (count_q == CNT_BITS'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ design/gtdf_front.sv @@
module gtdf_front
  import gtdf_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [PIX_BITS-1:0]   threshold_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_BITS-1:0]   red_i,
  input  logic [PIX_BITS-1:0]   green_i,
  input  logic [PIX_BITS-1:0]   blue_i,
  input  logic                  last_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output pix_t                  q_pix_o,
  output logic [COUNT_BITS-1:0] q_black_o,
  output logic [COUNT_BITS-1:0] q_total_o
);

  logic                  a_valid_q;
  logic [SUM_BITS-1:0]   a_sum_q, a_sum_d;
  logic                  a_last_q;
  logic                  a_ready, a_take;

  logic                  b_valid_q;
  pix_t                  b_pix_q, b_pix_d;
  logic                  b_ready, b_take;
  logic [PROD_BITS-1:0]  b_prod;

  logic [COUNT_BITS-1:0] black_q, black_d, total_q, total_d;
  logic [COUNT_BITS-1:0] black_inc, total_inc;

  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;
  assign a_take     = in_valid_i && a_ready;

  assign a_sum_d = W_RED * SUM_BITS'(red_i) + W_GREEN * SUM_BITS'(green_i)
                 + W_BLUE * SUM_BITS'(blue_i);

  assign b_ready = !b_valid_q || !q_full_i;
  assign b_take  = a_valid_q && b_ready;
  assign b_prod  = PROD_BITS'(a_sum_q) * PROD_BITS'(GRAY_RECIP);

  always_comb begin
    b_pix_d.gray  = b_prod[GRAY_SHIFT +: PIX_BITS];
    b_pix_d.white = (b_prod[GRAY_SHIFT +: PIX_BITS] > threshold_i);
    b_pix_d.last  = a_last_q;
  end

  assign q_push_o  = b_valid_q && !q_full_i;
  assign total_inc = (total_q == '1) ? total_q : total_q + 1'b1;
  assign black_inc = b_pix_q.white ? black_q
                   : ((black_q == '1) ? black_q : black_q + 1'b1);
  assign q_pix_o   = b_pix_q;
  assign q_black_o = black_inc;
  assign q_total_o = total_inc;

  always_comb begin
    black_d = black_q;
    total_d = total_q;
    if (q_push_o) begin
      black_d = b_pix_q.last ? '0 : black_inc;
      total_d = b_pix_q.last ? '0 : total_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      black_q   <= '0;
      total_q   <= '0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      black_q <= black_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_take) begin
      a_sum_q  <= a_sum_d;
      a_last_q <= last_i;
    end
    if (b_take) begin
      b_pix_q <= b_pix_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) black_q <= total_q)
    else $error("black count exceeds pixel count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (q_push_o && b_pix_q.last) |=> (total_q == '0 && black_q == '0))
    else $error("counters not cleared after frame end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (b_valid_q && q_full_i) |=> (b_valid_q && $stable(b_pix_q)))
    else $error("front stage lost a pixel under stall");

endmodule

@@ design/gtdf_back.sv @@
module gtdf_back
  import gtdf_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [PCT_BITS-1:0]   dark_pct_i,
  input  logic                  q_valid_i,
  output logic                  q_pop_o,
  input  pix_t                  q_pix_i,
  input  logic [COUNT_BITS-1:0] q_black_i,
  input  logic [COUNT_BITS-1:0] q_total_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pix_t                  out_pix_o,
  output logic                  out_dark_o
);

  localparam int unsigned MUL_BITS = COUNT_BITS + PCT_BITS;

  logic                c_valid_q;
  pix_t                c_pix_q;
  logic [MUL_BITS-1:0] c_black_q, c_total_q;
  logic                c_ready, c_take;

  logic                d_valid_q;
  pix_t                d_pix_q;
  logic                d_dark_q;
  logic                d_ready, d_take;

  assign d_ready = !d_valid_q || out_ready_i;
  assign c_ready = !c_valid_q || d_ready;
  assign q_pop_o = q_valid_i && c_ready;
  assign c_take  = q_pop_o;
  assign d_take  = c_valid_q && d_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid_q <= q_valid_i;
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_take) begin
      c_pix_q   <= q_pix_i;
      c_black_q <= MUL_BITS'(q_black_i) * MUL_BITS'(PCT_SCALE);
      c_total_q <= MUL_BITS'(q_total_i) * MUL_BITS'(dark_pct_i);
    end
    if (d_take) begin
      d_pix_q  <= c_pix_q;
      d_dark_q <= c_pix_q.last && (c_black_q > c_total_q);
    end
  end

  assign out_valid_o = d_valid_q;
  assign out_pix_o   = d_pix_q;
  assign out_dark_o  = d_dark_q;

endmodule

@@ design/gray_threshold_dark_frame_classifier_unit.sv @@
// Gray threshold dark frame classifier.
// Slave stream: one RGB pixel per beat, tdata = {blue, green, red} with red in
// the low byte, tlast marks the last pixel of a frame.
// Master stream: one result beat per pixel, tdata = gray level, tuser[0] =
// white pixel, tuser[1] = nearly black (only on the frame's last beat), tlast =
// frame done.
// Config channel: cfg_index_i 0 writes the binarize threshold, 1 writes the
// dark percentage; other indexes are ignored. Write only while the stream is
// idle; cfg_ready_o is always high.
// Throughput: one pixel per cycle sustained while m_axis_tready stays high.
// An input beat passes the sum, divide-by-100 and classify, queue, verdict
// multiply and output registers on its way to output tvalid.
// The front half classifies and counts, a 4-entry queue decouples it from the
// back half, which forms the frame verdict; a stalled receiver fills the
// queue and then drops s_axis_tready.
// Reset clears both frame counters, empties the pipeline and queue, and loads
// threshold 127 and dark percentage 50.
module gray_threshold_dark_frame_classifier_unit
  import gtdf_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [23:0]              s_axis_tdata,  // red, green, blue
  input  logic                     s_axis_tlast,  // frame_last
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,  // gray_level
  output logic [1:0]               m_axis_tuser,  // white_pixel, nearly_black
  output logic                     m_axis_tlast   // frame_done
);

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_WIDTH = $bits(pix_t) + 2 * COUNT_BITS;

  logic [PIX_BITS-1:0]   threshold_q;
  logic [PCT_BITS-1:0]   dark_q;

  logic                  q_push, q_full, q_pop, q_valid;
  pix_t                  push_pix, pop_pix, out_pix;
  logic [COUNT_BITS-1:0] push_black, push_total, pop_black, pop_total;
  logic [Q_WIDTH-1:0]    push_data, pop_data;
  logic                  out_dark;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RST;
      dark_q      <= DARK_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD: threshold_q <= cfg_data_i[PIX_BITS-1:0];
        CFG_DARK:      dark_q      <= cfg_data_i[PCT_BITS-1:0];
        default:       ;
      endcase
    end
  end

  gtdf_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .threshold_i(threshold_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .red_i      (s_axis_tdata[7:0]),
    .green_i    (s_axis_tdata[15:8]),
    .blue_i     (s_axis_tdata[23:16]),
    .last_i     (s_axis_tlast),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_pix_o    (push_pix),
    .q_black_o  (push_black),
    .q_total_o  (push_total)
  );

  assign push_data = {push_black, push_total, push_pix};
  assign {pop_black, pop_total, pop_pix} = pop_data;

  gtdf_queue #(
    .WIDTH(Q_WIDTH),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(push_data),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_data_o (pop_data),
    .valid_o    (q_valid)
  );

  gtdf_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dark_pct_i (dark_q),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_pix_i    (pop_pix),
    .q_black_i  (pop_black),
    .q_total_i  (pop_total),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_pix_o  (out_pix),
    .out_dark_o (out_dark)
  );

  assign m_axis_tdata = out_pix.gray;
  assign m_axis_tuser = {out_dark, out_pix.white};
  assign m_axis_tlast = out_pix.last;

endmodule
